// ===== hdl/rssf_pkg.sv =====
package rssf_pkg;

	localparam int unsigned NUM_CHAN     = 3;
	localparam int unsigned CHAN_W       = 8;
	localparam int unsigned MAX_COLS_DEF = 1024;
	localparam int unsigned MAX_ROWS     = 4096;
	localparam int unsigned ROW_W        = 12;
	localparam int unsigned FW_W         = 11;
	localparam int unsigned FH_W         = 13;
	localparam int unsigned APB_AW       = 4;
	localparam int unsigned APB_DW       = 32;

	// floor(x/9) == (x*7282)>>16 for every x below 32768
	localparam int unsigned DIV9_MUL   = 7282;
	localparam int unsigned DIV9_SHIFT = 16;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(1024);
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(4096);

	// register indexes, byte address is 4*index
	localparam logic [1:0] REG_FILTER_MODE  = 2'd0;
	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

	localparam logic MODE_SHARPEN = 1'b0;
	localparam logic MODE_SMOOTH  = 1'b1;

	// channel 0 red, 1 green, 2 blue
	typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;
	typedef pixel_t [2:0] win_row_t;
	typedef win_row_t [2:0] window_t;

	typedef struct packed {
		pixel_t upper;
		pixel_t middle;
	} ls_entry_t;

	typedef struct packed {
		logic            filter_mode;
		logic [FW_W-1:0] frame_width;
		logic [FH_W-1:0] frame_height;
	} cfg_t;

endpackage

// ===== hdl/rssf_regs.sv =====
module rssf_regs
	import rssf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_mode  <= MODE_SHARPEN;
			cfg_q.frame_width  <= FRAME_WIDTH_RST;
			cfg_q.frame_height <= FRAME_HEIGHT_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_FILTER_MODE:  cfg_q.filter_mode  <= pwdata[0];
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= pwdata[FW_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= pwdata[FH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_FILTER_MODE:  prdata = APB_DW'(cfg_q.filter_mode);
			REG_FRAME_WIDTH:  prdata = APB_DW'(cfg_q.frame_width);
			REG_FRAME_HEIGHT: prdata = APB_DW'(cfg_q.frame_height);
			default:          prdata = '0;
		endcase
	end

endmodule

// ===== hdl/rssf_line_store.sv =====
module rssf_line_store
	import rssf_pkg::*;
#(
	parameter int unsigned MAX_COLS = MAX_COLS_DEF,
	parameter int unsigned AW       = $clog2(MAX_COLS)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output ls_entry_t     rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  ls_entry_t     wr_data
);

	// both previous rows side by side, one entry per column
	ls_entry_t mem [MAX_COLS];
	ls_entry_t rd_q;

	assign rd_data = rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/rssf_kernel.sv =====
module rssf_kernel
	import rssf_pkg::*;
(
	input  logic    filter_mode,
	input  window_t win,
	output pixel_t  pix
);

	logic [11:0] sum9  [NUM_CHAN];
	logic [24:0] prod9 [NUM_CHAN];
	logic [10:0] pos5  [NUM_CHAN];
	logic [9:0]  neg4  [NUM_CHAN];
	logic [10:0] diff  [NUM_CHAN];

	always_comb begin
		for (int ch = 0; ch < NUM_CHAN; ch++) begin
			sum9[ch] = '0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					sum9[ch] = sum9[ch] + 12'(win[r][c][ch]);
				end
			end
			prod9[ch] = 25'(sum9[ch]) * 25'(DIV9_MUL);

			// center times 5 less the up, down, left and right neighbors, clamped to 0..255
			pos5[ch] = 11'(win[1][1][ch]) * 11'd5;
			neg4[ch] = 10'(win[0][1][ch]) + 10'(win[1][0][ch])
				+ 10'(win[1][2][ch]) + 10'(win[2][1][ch]);
			diff[ch] = pos5[ch] - 11'(neg4[ch]);

			if (filter_mode == MODE_SMOOTH) begin
				pix[ch] = prod9[ch][DIV9_SHIFT +: CHAN_W];
			end else if (11'(neg4[ch]) > pos5[ch]) begin
				pix[ch] = '0;
			end else if (diff[ch] > 11'd255) begin
				pix[ch] = 8'd255;
			end else begin
				pix[ch] = diff[ch][CHAN_W-1:0];
			end
		end
	end

endmodule

// ===== hdl/rgb_sharpen_smooth_3x3_filter_unit.sv =====
// channel   | ports                                   | direction
// ----------+-----------------------------------------+----------
// pixel     | pix_valid, pix_stall, red_in, green_in, | in
//           | blue_in                                 |
// result    | res_valid, res_stall, red_out,          | out
//           | green_out, blue_out, frame_last         |
// config    | psel, penable, pwrite, paddr, pwdata,   | in/out
//           | prdata, pready                          |
//
// one pixel item per clock sustained unless res_stall holds the result;
// a result passes the line store read, window register and result register
// arst_n clears counters, window, valids and config registers; line stores start unknown
// every stage advances together; pix_stall is high only while the result
// register holds an item that res_stall keeps
module rgb_sharpen_smooth_3x3_filter_unit
	import rssf_pkg::*;
#(
	parameter int unsigned MAX_COLS = MAX_COLS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              pix_valid,
	output logic              pix_stall,
	input  logic [7:0]        red_in,
	input  logic [7:0]        green_in,
	input  logic [7:0]        blue_in,

	output logic              res_valid,
	input  logic              res_stall,
	output logic [7:0]        red_out,
	output logic [7:0]        green_out,
	output logic [7:0]        blue_out,
	output logic              frame_last,

	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int unsigned CW = $clog2(MAX_COLS);
	// wide enough for the column limit and for MAX_COLS itself
	localparam int unsigned LW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

	cfg_t cfg;

	// configuration registers
	rssf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// pipeline moves as one unless the result register is held
	logic adv;
	logic accept;

	logic             res_valid_q;
	pixel_t           res_pix_q;
	logic             res_last_q;

	assign adv       = !(res_valid_q && res_stall);
	assign pix_stall = !adv;
	assign accept    = pix_valid && adv;

	// column and row position of the incoming pixel
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [LW-1:0]    fw_ext;
	logic [LW-1:0]    col_lim;
	logic [FH_W-1:0]  row_lim;
	logic             last_col;
	logic             last_row;
	logic             emit;

	always_comb begin
		fw_ext = LW'(cfg.frame_width);
		// out of range width acts as 3 or as the line store depth
		if (fw_ext < LW'(3)) begin
			col_lim = LW'(2);
		end else if (fw_ext > LW'(MAX_COLS)) begin
			col_lim = LW'(MAX_COLS - 1);
		end else begin
			col_lim = fw_ext - LW'(1);
		end
		if (cfg.frame_height < FH_W'(3)) begin
			row_lim = FH_W'(2);
		end else if (cfg.frame_height > FH_W'(MAX_ROWS)) begin
			row_lim = FH_W'(MAX_ROWS - 1);
		end else begin
			row_lim = cfg.frame_height - FH_W'(1);
		end
		last_col = LW'(col_q) >= col_lim;
		last_row = FH_W'(row_q) >= row_lim;
		// window is complete from the third column on, in the third row and later rows
		emit = (row_q >= ROW_W'(2)) && (col_q >= CW'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// stage 1: incoming pixel, line store read data
	logic          valid_s1;
	pixel_t        px_s1;
	logic [CW-1:0] addr_s1;
	logic          emit_s1;
	logic          last_s1;
	ls_entry_t     rd_s1;
	ls_entry_t     wr_entry;
	logic          move_s1;

	assign move_s1           = adv && valid_s1;
	// upper row takes the old middle row, middle row takes the new pixel
	assign wr_entry.upper    = rd_s1.middle;
	assign wr_entry.middle   = px_s1;

	rssf_line_store #(
		.MAX_COLS (MAX_COLS),
		.AW       (CW)
	) u_line_store (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (rd_s1),
		.wr_en   (move_s1),
		.wr_addr (addr_s1),
		.wr_data (wr_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= {blue_in, green_in, red_in};
			addr_s1 <= col_q;
			emit_s1 <= emit;
			last_s1 <= last_col && last_row;
		end
	end

	// stage 2: 3x3 window, row 0 top, column 2 newest
	window_t win_s2;
	logic    valid_s2;
	logic    emit_s2;
	logic    last_s2;
	pixel_t  filt_pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			emit_s2  <= 1'b0;
			last_s2  <= 1'b0;
			win_s2   <= '0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				emit_s2 <= emit_s1;
				last_s2 <= last_s1;
				for (int r = 0; r < 3; r++) begin
					win_s2[r][0] <= win_s2[r][1];
					win_s2[r][1] <= win_s2[r][2];
				end
				win_s2[0][2] <= rd_s1.upper;
				win_s2[1][2] <= rd_s1.middle;
				win_s2[2][2] <= px_s1;
			end
		end
	end

	// sharpen or box average of the window center
	rssf_kernel u_kernel (
		.filter_mode (cfg.filter_mode),
		.win         (win_s2),
		.pix         (filt_pix)
	);

	// result register, parts the two handshakes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_last_q  <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s2 && emit_s2;
			if (valid_s2 && emit_s2) begin
				res_last_q <= last_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2 && emit_s2) begin
			res_pix_q <= filt_pix;
		end
	end

	assign res_valid  = res_valid_q;
	assign red_out    = res_pix_q[0];
	assign green_out  = res_pix_q[1];
	assign blue_out   = res_pix_q[2];
	assign frame_last = res_last_q;

endmodule
